>>> sv/dpcd_pkg.sv
// ----------------------------------------------------------------------------
// dpcd_pkg: shared types and constants of the patch command decoder
// Phase and kind codes, character codes and the command item that passes
// from the parser to the output side.
// ----------------------------------------------------------------------------
package dpcd_pkg;

    localparam int RUN_W   = 31;
    localparam int LIT_W   = 8;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [7:0] CH_COPY   = 8'h63;
    localparam logic [7:0] CH_SKIP   = 8'h73;
    localparam logic [7:0] CH_INSERT = 8'h69;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_DIGITS,
        PH_LIT,
        PH_CLOSE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_COPY,
        KIND_SKIP,
        KIND_INSERT,
        KIND_IGNORED
    } kind_t;

    typedef struct packed {
        logic             done;
        logic [LIT_W-1:0] literal;
        logic [RUN_W-1:0] run_length;
        kind_t            kind;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

>>> sv/dpcd_front.sv
// ----------------------------------------------------------------------------
// dpcd_front: patch byte parser
// Classifies each accepted byte, builds the decimal count and produces copy,
// skip and literal commands for the queue.
// ----------------------------------------------------------------------------
module dpcd_front #(
    parameter int COUNT_BITS = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    output logic             push,
    output dpcd_pkg::cmd_t   push_cmd
);

    localparam int CW = (COUNT_BITS > 31) ? 31 : COUNT_BITS;
    localparam logic [CW+3:0] CNT_MAX = {4'b0000, {CW{1'b1}}};

    dpcd_pkg::phase_t phase_reg, phase_next, phase_raw;
    dpcd_pkg::kind_t  kind_reg, kind_next, kind_raw;
    logic [CW-1:0]    acc_reg, acc_next, acc_raw, acc_dec;
    logic             is_digit;
    logic [3:0]       digit;
    logic [CW+3:0]    prod;
    dpcd_pkg::kind_t  byte_kind;
    logic             emit;

    assign digit    = in_byte[3:0];
    assign is_digit = (in_byte >= dpcd_pkg::CH_ZERO) && (in_byte <= dpcd_pkg::CH_NINE);
    assign prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {{CW{1'b0}}, digit};
    assign acc_dec  = (acc_reg != '0) ? acc_reg - 1'b1 : acc_reg;

    always_comb
    begin
        unique case (in_byte)
            dpcd_pkg::CH_COPY:   byte_kind = dpcd_pkg::KIND_COPY;
            dpcd_pkg::CH_SKIP:   byte_kind = dpcd_pkg::KIND_SKIP;
            dpcd_pkg::CH_INSERT: byte_kind = dpcd_pkg::KIND_INSERT;
            default:             byte_kind = dpcd_pkg::KIND_IGNORED;
        endcase
    end

    always_comb
    begin
        phase_raw = phase_reg;
        kind_raw  = kind_reg;
        acc_raw   = acc_reg;
        unique case (phase_reg)
            dpcd_pkg::PH_CMD:
            begin
                phase_raw = dpcd_pkg::PH_DIGITS;
                kind_raw  = byte_kind;
                acc_raw   = '0;
            end
            dpcd_pkg::PH_DIGITS:
            begin
                if (is_digit)
                begin
                    acc_raw = (prod > CNT_MAX) ? CNT_MAX[CW-1:0] : prod[CW-1:0];
                end
                else if (kind_reg == dpcd_pkg::KIND_INSERT)
                begin
                    phase_raw = (acc_reg != '0) ? dpcd_pkg::PH_LIT : dpcd_pkg::PH_CLOSE;
                end
                else
                begin
                    kind_raw = byte_kind;
                    acc_raw  = '0;
                end
            end
            dpcd_pkg::PH_LIT:
            begin
                acc_raw = acc_dec;
                if (acc_dec == '0)
                begin
                    phase_raw = dpcd_pkg::PH_CLOSE;
                end
            end
            default:
            begin
                phase_raw = dpcd_pkg::PH_CMD;
            end
        endcase
    end

    always_comb
    begin
        phase_next = in_final ? dpcd_pkg::PH_CMD : phase_raw;
        kind_next  = in_final ? dpcd_pkg::KIND_COPY : kind_raw;
        acc_next   = in_final ? '0 : acc_raw;
    end

    always_comb
    begin
        emit                = 1'b0;
        push_cmd.kind       = kind_reg;
        push_cmd.run_length = dpcd_pkg::RUN_W'(acc_reg);
        push_cmd.literal    = '0;
        push_cmd.done       = in_final;
        if (phase_reg == dpcd_pkg::PH_DIGITS && !is_digit &&
            (kind_reg == dpcd_pkg::KIND_COPY || kind_reg == dpcd_pkg::KIND_SKIP))
        begin
            emit = 1'b1;
        end
        else if (phase_reg == dpcd_pkg::PH_LIT)
        begin
            emit                = 1'b1;
            push_cmd.kind       = dpcd_pkg::KIND_INSERT;
            push_cmd.run_length = '0;
            push_cmd.literal    = in_byte;
        end
        else if (in_final && phase_raw == dpcd_pkg::PH_DIGITS &&
                 (kind_raw == dpcd_pkg::KIND_COPY || kind_raw == dpcd_pkg::KIND_SKIP))
        begin
            emit                = 1'b1;
            push_cmd.kind       = kind_raw;
            push_cmd.run_length = dpcd_pkg::RUN_W'(acc_raw);
        end
    end

    assign push = in_fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dpcd_pkg::PH_CMD;
            kind_reg  <= dpcd_pkg::KIND_COPY;
            acc_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

>>> sv/dpcd_queue.sv
// ----------------------------------------------------------------------------
// dpcd_queue: command queue
// Short first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module dpcd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dpcd_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output dpcd_pkg::cmd_t   head,
    output dpcd_pkg::qstat_t stat
);

    dpcd_pkg::cmd_t                 mem [dpcd_pkg::Q_DEPTH];
    logic [dpcd_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [dpcd_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [dpcd_pkg::Q_CNT_W-1:0]   count_reg;
    logic [dpcd_pkg::Q_CNT_W-1:0]   count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == dpcd_pkg::Q_CNT_W'(dpcd_pkg::Q_DEPTH));
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dpcd_pkg::Q_CNT_W'(dpcd_pkg::Q_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[dpcd_pkg::Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> sv/dpcd_back.sv
// ----------------------------------------------------------------------------
// dpcd_back: command output stage
// Takes commands from the queue into the output register and packs them
// onto the master stream.
// ----------------------------------------------------------------------------
module dpcd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dpcd_pkg::cmd_t   head,
    input  dpcd_pkg::qstat_t stat,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic           out_valid_reg;
    dpcd_pkg::cmd_t out_cmd_reg;

    assign pop = !stat.empty && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= !stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_cmd_reg <= head;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_cmd_reg.literal, out_cmd_reg.run_length,
                            out_cmd_reg.kind};
    assign m_axis_tlast  = out_cmd_reg.done;

endmodule

>>> sv/delta_patch_command_decoder_top.sv
// ----------------------------------------------------------------------------
// delta_patch_command_decoder_top: textual patch stream to command decoder
// Usage: feed patch bytes on the s_axis channel, one byte per item, with
// s_axis_tlast on the last byte of the stream. Copy and skip commands with
// their counts and inserted literal bytes leave on the m_axis channel;
// m_axis_tlast marks a command produced by the last byte.
// A byte is accepted in every cycle while the four-entry command queue has
// room, so the sustained rate is one byte per cycle; each byte yields at
// most one command. A command passes from the parser into the queue and
// then from the queue into the output register before it leaves.
// When the receiver stalls, commands collect in the queue and the output
// register; s_axis_tready drops once the queue is full and rises again as
// soon as an entry is taken.
// Reset clears the parser to wait for a command byte and empties the queue
// and output register.
// ----------------------------------------------------------------------------
module delta_patch_command_decoder_top #(
    parameter int COUNT_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] patch_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] command_kind, [32:2] run_length,
                                        // [40:33] literal_value, [47:41] zero
    output logic        m_axis_tlast    // stream_done
);

    logic             in_fire;
    logic             push;
    logic             pop;
    dpcd_pkg::cmd_t   push_cmd;
    dpcd_pkg::cmd_t   head;
    dpcd_pkg::qstat_t stat;

    assign s_axis_tready = !stat.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    dpcd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_byte  (s_axis_tdata),
        .in_final (s_axis_tlast),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dpcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    dpcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
